### rtl/mdt_pkg.sv
`default_nettype none

package mdt_pkg;

   localparam int TABLE_DEPTH   = 32;
   localparam int KEY_BYTES     = 6;
   localparam int KEY_W         = 8 * KEY_BYTES;
   localparam int TIME_W        = 48;
   localparam int IDENT_W       = 16;
   localparam int SLOT_W        = $clog2(TABLE_DEPTH);
   localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
   localparam int SLOT_FIELD_W  = 5;
   localparam int COUNT_FIELD_W = 6;

   typedef enum logic [1:0] {
      REQ_TOUCH    = 2'd0,
      REQ_FIND     = 2'd1,
      REQ_REMOVE   = 2'd2,
      REQ_RESERVED = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_FOUND     = 2'd0,
      ST_CREATED   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_code_type;

   typedef enum logic [1:0] {
      WR_NONE    = 2'd0,
      WR_CREATE  = 2'd1,
      WR_REFRESH = 2'd2,
      WR_REMOVE  = 2'd3
   } wr_op_type;

   typedef struct packed {
      req_code_type       req_type;
      logic [KEY_W-1:0]   mac_addr;
      logic [TIME_W-1:0]  now_time;
   } req_item_type;

   typedef struct packed {
      status_code_type          status;
      logic [SLOT_FIELD_W-1:0]  slot_index;
      logic [IDENT_W-1:0]       device_ident;
      logic [TIME_W-1:0]        seen_time;
      logic [TIME_W-1:0]        created_time;
      logic [COUNT_FIELD_W-1:0] entry_count;
   } rsp_item_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic               active;
      logic [KEY_W-1:0]   key;
      logic               hit;
      logic [SLOT_W-1:0]  hit_slot;
      logic [IDENT_W-1:0] hit_ident;
      logic [TIME_W-1:0]  hit_seen;
      logic [TIME_W-1:0]  hit_created;
      logic               free;
      logic [SLOT_W-1:0]  free_slot;
   } probe_type;

   // write-back broadcast to every cell
   typedef struct packed {
      wr_op_type          op;
      logic [SLOT_W-1:0]  slot;
      logic [KEY_W-1:0]   key;
      logic [IDENT_W-1:0] ident;
      logic [TIME_W-1:0]  now;
   } write_cmd_type;

endpackage

`default_nettype wire

### rtl/mac_keyed_device_table.sv
// Flow: a request accepted into the head token register walks the chain of TABLE_DEPTH cell
// registers (32 slots), is captured at the chain end in the tail register and then gives its
// response through the response register, which waits while rsp_stall holds a waiting response.
// One request at a time: req_stall holds off the next one while the token walks the cell
// chain; the next request is taken at the edge after the response register loads, and later
// while rsp_stall holds a waiting response.
// Reset (synchronous, active high) clears all valid bits, the entry count and the id counter;
// entry contents are not cleared and are only read behind their valid bit.
`default_nettype none

module mac_keyed_device_table
   import mdt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_payload,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_payload
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SCAN  = 3'b010,
      S_REPLY = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   probe_type          head_ff;
   probe_type          tail_ff;
   req_item_type       req_ff;
   logic [IDENT_W-1:0] next_ident_ff, next_ident_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff;
   rsp_item_type       rsp_ff, rsp_in;
   write_cmd_type      wr_plan, wr_live;
   probe_type          link [TABLE_DEPTH+1];
   logic               accept;
   logic               out_free;
   logic               finish;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finish    = (state_ff == S_REPLY) && out_free;

   assign link[0] = head_ff;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      mdt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (SLOT_W'(i)),
         .tok_i      (link[i]),
         .wr_i       (wr_live),
         .tok_o      (link[i+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_SCAN;
         S_SCAN:  if (link[TABLE_DEPTH].active) state_in = S_REPLY;
         S_REPLY: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // decide the result and the write-back from the finished token
   always_comb begin
      wr_plan.op    = WR_NONE;
      wr_plan.slot  = tail_ff.hit_slot;
      wr_plan.key   = req_ff.mac_addr;
      wr_plan.ident = next_ident_ff;
      wr_plan.now   = req_ff.now_time;
      next_ident_in = next_ident_ff;
      count_in      = count_ff;

      rsp_in.status       = ST_NOT_FOUND;
      rsp_in.slot_index   = '0;
      rsp_in.device_ident = '0;
      rsp_in.seen_time    = '0;
      rsp_in.created_time = '0;

      case (req_ff.req_type)
         REQ_TOUCH: begin
            if (tail_ff.hit) begin
               wr_plan.op          = WR_REFRESH;
               rsp_in.status       = ST_FOUND;
               rsp_in.slot_index   = SLOT_FIELD_W'(tail_ff.hit_slot);
               rsp_in.device_ident = tail_ff.hit_ident;
               rsp_in.seen_time    = req_ff.now_time;
               rsp_in.created_time = tail_ff.hit_created;
            end else if (tail_ff.free) begin
               wr_plan.op          = WR_CREATE;
               wr_plan.slot        = tail_ff.free_slot;
               next_ident_in       = next_ident_ff + 1'b1;
               count_in            = count_ff + 1'b1;
               rsp_in.status       = ST_CREATED;
               rsp_in.slot_index   = SLOT_FIELD_W'(tail_ff.free_slot);
               rsp_in.device_ident = next_ident_ff;
               rsp_in.seen_time    = req_ff.now_time;
               rsp_in.created_time = req_ff.now_time;
            end else begin
               rsp_in.status = ST_FULL;
            end
         end
         REQ_FIND: begin
            if (tail_ff.hit) begin
               rsp_in.status       = ST_FOUND;
               rsp_in.slot_index   = SLOT_FIELD_W'(tail_ff.hit_slot);
               rsp_in.device_ident = tail_ff.hit_ident;
               rsp_in.seen_time    = tail_ff.hit_seen;
               rsp_in.created_time = tail_ff.hit_created;
            end
         end
         REQ_REMOVE: begin
            if (tail_ff.hit) begin
               wr_plan.op          = WR_REMOVE;
               if (count_ff != '0) count_in = count_ff - 1'b1;
               rsp_in.status       = ST_FOUND;
               rsp_in.slot_index   = SLOT_FIELD_W'(tail_ff.hit_slot);
               rsp_in.device_ident = tail_ff.hit_ident;
               rsp_in.seen_time    = tail_ff.hit_seen;
               rsp_in.created_time = tail_ff.hit_created;
            end
         end
         default: begin
            rsp_in.status = ST_NOT_FOUND;
         end
      endcase

      rsp_in.entry_count = COUNT_FIELD_W'(count_in);
   end

   always_comb begin
      wr_live = wr_plan;
      if (!finish) wr_live.op = WR_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         head_ff.active <= 1'b0;
         next_ident_ff  <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;

         head_ff.active <= accept;
         if (accept) begin
            head_ff.key         <= req_payload.mac_addr;
            head_ff.hit         <= 1'b0;
            head_ff.hit_slot    <= '0;
            head_ff.hit_ident   <= '0;
            head_ff.hit_seen    <= '0;
            head_ff.hit_created <= '0;
            head_ff.free        <= 1'b0;
            head_ff.free_slot   <= '0;
         end

         if (finish) begin
            next_ident_ff <= next_ident_in;
            count_ff      <= count_in;
         end

         if (finish) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
      end
      if ((state_ff == S_SCAN) && link[TABLE_DEPTH].active) begin
         tail_ff <= link[TABLE_DEPTH];
      end
      if (finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

### rtl/mdt_cell.sv
`default_nettype none

module mdt_cell
   import mdt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [SLOT_W-1:0] cell_index,
   input  wire probe_type         tok_i,
   input  wire write_cmd_type     wr_i,
   output probe_type              tok_o
);

   logic               valid_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [IDENT_W-1:0] ident_ff;
   logic [TIME_W-1:0]  seen_ff;
   logic [TIME_W-1:0]  created_ff;
   probe_type          tok_ff;
   probe_type          tok_in;
   logic               sel;
   logic               match;

   assign sel   = (wr_i.op != WR_NONE) && (wr_i.slot == cell_index);
   assign match = valid_ff && (key_ff == tok_i.key);

   always_comb begin
      tok_in = tok_i;
      if (tok_i.active) begin
         // lowest matching slot wins: the first cell to hit marks the token
         if (!tok_i.hit && match) begin
            tok_in.hit         = 1'b1;
            tok_in.hit_slot    = cell_index;
            tok_in.hit_ident   = ident_ff;
            tok_in.hit_seen    = seen_ff;
            tok_in.hit_created = created_ff;
         end
         if (!tok_i.free && !valid_ff) begin
            tok_in.free      = 1'b1;
            tok_in.free_slot = cell_index;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (sel) begin
         case (wr_i.op)
            WR_CREATE: valid_ff <= 1'b1;
            WR_REMOVE: valid_ff <= 1'b0;
            default:   valid_ff <= valid_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (sel) begin
         case (wr_i.op)
            WR_CREATE: begin
               key_ff     <= wr_i.key;
               ident_ff   <= wr_i.ident;
               seen_ff    <= wr_i.now;
               created_ff <= wr_i.now;
            end
            WR_REFRESH: begin
               seen_ff <= wr_i.now;
            end
            default: begin
               seen_ff <= seen_ff;
            end
         endcase
      end
   end

   assign tok_o = tok_ff;

endmodule

`default_nettype wire

### rtl/mdt_checker.sv
`default_nettype none

module mdt_checker
   import mdt_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire req_item_type req_payload,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_item_type rsp_payload
);

   // a stalled response transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // one request in flight: after a transaction is taken the block is busy
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a search is running");

   a_full_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == ST_FULL) |->
         (rsp_payload.slot_index == '0) && (rsp_payload.device_ident == '0) &&
         (rsp_payload.entry_count == COUNT_FIELD_W'(TABLE_DEPTH)))
      else $error("table-full response inconsistent");

   a_created_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == ST_CREATED) |->
         (rsp_payload.entry_count != '0) &&
         (rsp_payload.seen_time == rsp_payload.created_time))
      else $error("created response inconsistent");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == ST_NOT_FOUND) |->
         (rsp_payload.seen_time == '0) && (rsp_payload.created_time == '0))
      else $error("not-found response carries entry data");

endmodule

bind mac_keyed_device_table mdt_checker u_checker (.*);

`default_nettype wire

### bench/tb_mac_keyed_device_table.sv
module tb_mac_keyed_device_table;
   import mdt_pkg::*;

   localparam int RANDOM_ITEMS = 700;
   localparam int KEY_POOL     = 48;
   localparam int STUCK_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
   localparam int MAX_PRINTS   = 200;
   localparam logic [KEY_W-1:0]  KEY_MAX  = '1;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   typedef struct {
      req_item_type item;
      bit           typed;
      rsp_item_type reply;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_payload;

   // device table as the predictor sees it
   bit                 tbl_valid   [TABLE_DEPTH];
   logic [KEY_W-1:0]   tbl_key     [TABLE_DEPTH];
   logic [IDENT_W-1:0] tbl_ident   [TABLE_DEPTH];
   logic [TIME_W-1:0]  tbl_seen    [TABLE_DEPTH];
   logic [TIME_W-1:0]  tbl_created [TABLE_DEPTH];
   logic [IDENT_W-1:0] tbl_next_ident = '0;
   int                 tbl_count = 0;

   stim_row_type stim_rows [$];
   rsp_item_type pending_replies [$];
   int           issue_idx    = 0;
   int           reply_count  = 0;
   int           stuck_cycles = 0;
   int           error_count  = 0;

   mac_keyed_device_table u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic flag_error(input string what);
      error_count++;
      if (error_count <= MAX_PRINTS)
         $display("ERROR @%0t: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         flag_error($sformatf("reply %0d %s: got %0h, expected %0h",
                              reply_count, name, got, want));
   endtask

   function automatic logic [47:0] rand48();
      logic [63:0] v;
      v = {$urandom(), $urandom()};
      return v[47:0];
   endfunction

   function automatic rsp_item_type reply_of(input status_code_type st, input int slot,
                                             input int ident, input logic [TIME_W-1:0] seen,
                                             input logic [TIME_W-1:0] created,
                                             input int count);
      rsp_item_type o;
      o.status       = st;
      o.slot_index   = SLOT_FIELD_W'(slot);
      o.device_ident = IDENT_W'(ident);
      o.seen_time    = seen;
      o.created_time = created;
      o.entry_count  = COUNT_FIELD_W'(count);
      return o;
   endfunction

   function automatic void add_row(input req_code_type op, input logic [KEY_W-1:0] mac,
                                   input logic [TIME_W-1:0] now, input bit typed,
                                   input rsp_item_type reply);
      stim_row_type row;
      row.item.req_type = op;
      row.item.mac_addr = mac;
      row.item.now_time = now;
      row.typed         = typed;
      row.reply         = reply;
      stim_rows.push_back(row);
   endfunction

   // applies one transaction to the table and returns the reply it gives
   function automatic rsp_item_type table_update(input req_item_type r);
      rsp_item_type o;
      int hit;
      int free_slot;
      int pick;
      hit       = -1;
      free_slot = -1;
      pick      = -1;
      // downward scan leaves the lowest matching and lowest free slot
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (tbl_valid[i] && tbl_key[i] == r.mac_addr) hit = i;
         if (!tbl_valid[i]) free_slot = i;
      end
      o        = '0;
      o.status = ST_NOT_FOUND;
      case (r.req_type)
         REQ_TOUCH: begin
            if (hit < 0 && free_slot < 0) begin
               o.status = ST_FULL;
            end else begin
               if (hit < 0) begin
                  hit              = free_slot;
                  tbl_valid[hit]   = 1'b1;
                  tbl_key[hit]     = r.mac_addr;
                  tbl_ident[hit]   = tbl_next_ident;
                  tbl_next_ident   = tbl_next_ident + 1'b1;
                  tbl_created[hit] = r.now_time;
                  tbl_count++;
                  o.status = ST_CREATED;
               end else begin
                  o.status = ST_FOUND;
               end
               tbl_seen[hit] = r.now_time;
               pick = hit;
            end
         end
         REQ_FIND: begin
            if (hit >= 0) begin
               o.status = ST_FOUND;
               pick = hit;
            end
         end
         REQ_REMOVE: begin
            if (hit >= 0) begin
               tbl_valid[hit] = 1'b0;
               if (tbl_count > 0) tbl_count--;
               o.status = ST_FOUND;
               pick = hit;
            end
         end
         default: ;
      endcase
      if (pick >= 0) begin
         o.slot_index   = SLOT_FIELD_W'(pick);
         o.device_ident = tbl_ident[pick];
         o.seen_time    = tbl_seen[pick];
         o.created_time = tbl_created[pick];
      end
      o.entry_count = COUNT_FIELD_W'(tbl_count);
      return o;
   endfunction

   always @(posedge clock) begin : handshake
      rsp_item_type want;
      bit           took;
      if (reset) begin
         req_valid    <= 1'b0;
         rsp_stall    <= 1'b0;
         stuck_cycles = 0;
      end else begin
         took = 1'b0;
         if (req_valid && !req_stall) begin
            want = table_update(req_payload);
            if (stim_rows[issue_idx].typed) want = stim_rows[issue_idx].reply;
            pending_replies.push_back(want);
            issue_idx++;
            took = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            took = 1'b1;
            if (pending_replies.size() == 0) begin
               flag_error($sformatf("reply %0d with no transaction waiting", reply_count));
            end else begin
               want = pending_replies.pop_front();
               check_field("status", 64'(rsp_payload.status), 64'(want.status));
               check_field("slot_index", 64'(rsp_payload.slot_index), 64'(want.slot_index));
               check_field("device_ident", 64'(rsp_payload.device_ident),
                           64'(want.device_ident));
               check_field("seen_time", 64'(rsp_payload.seen_time), 64'(want.seen_time));
               check_field("created_time", 64'(rsp_payload.created_time),
                           64'(want.created_time));
               check_field("entry_count", 64'(rsp_payload.entry_count),
                           64'(want.entry_count));
            end
            reply_count++;
         end
         stuck_cycles = took ? 0 : stuck_cycles + 1;

         // payload only moves when the current transaction is gone or never was
         if (!req_valid || !req_stall) begin
            if (issue_idx < stim_rows.size() &&
                ((issue_idx >= 300 && issue_idx < 400) || $urandom_range(0, 99) >= 15)) begin
               req_valid   <= 1'b1;
               req_payload <= stim_rows[issue_idx].item;
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (reply_count >= 300 && reply_count < 400)
            rsp_stall <= 1'b0;
         else
            rsp_stall <= ($urandom_range(0, 99) < 15);
      end
   end

   initial begin : watchdog
      while (stuck_cycles < STUCK_LIMIT) @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : sequencer
      logic [KEY_W-1:0]  pool [KEY_POOL];
      logic [KEY_W-1:0]  k2;
      logic [TIME_W-1:0] t2;
      int                n_directed;
      int                mode;
      int                len;
      int                base;
      int                roll;
      req_code_type      op;
      logic [KEY_W-1:0]  mac;

      pool[0] = '0;
      pool[1] = KEY_MAX;
      for (int i = 2; i < KEY_POOL; i++) pool[i] = rand48();

      k2 = 48'hA5A5_5A5A_0F0F;
      t2 = 48'h5555_AAAA_5555;
      add_row(REQ_FIND,     '0,      '0, 1'b1, reply_of(ST_NOT_FOUND, 0, 0, '0, '0, 0));
      add_row(REQ_REMOVE,   KEY_MAX, '0, 1'b1, reply_of(ST_NOT_FOUND, 0, 0, '0, '0, 0));
      add_row(REQ_RESERVED, '0,      '0, 1'b1, reply_of(ST_NOT_FOUND, 0, 0, '0, '0, 0));
      add_row(REQ_TOUCH,    '0,      '0, 1'b1, reply_of(ST_CREATED, 0, 0, '0, '0, 1));
      add_row(REQ_TOUCH, KEY_MAX, TIME_MAX, 1'b1,
              reply_of(ST_CREATED, 1, 1, TIME_MAX, TIME_MAX, 2));
      add_row(REQ_TOUCH, '0, 48'h123, 1'b1, reply_of(ST_FOUND, 0, 0, 48'h123, '0, 2));
      add_row(REQ_FIND, KEY_MAX, '0, 1'b1, reply_of(ST_FOUND, 1, 1, TIME_MAX, TIME_MAX, 2));
      // reserved request is ignored even when the key is present
      add_row(REQ_RESERVED, KEY_MAX, 48'd5, 1'b1, reply_of(ST_NOT_FOUND, 0, 0, '0, '0, 2));
      add_row(REQ_REMOVE, '0, '0, 1'b1, reply_of(ST_FOUND, 0, 0, 48'h123, '0, 1));
      add_row(REQ_FIND,   '0, '0, 1'b1, reply_of(ST_NOT_FOUND, 0, 0, '0, '0, 1));
      add_row(REQ_REMOVE, '0, '0, 1'b1, reply_of(ST_NOT_FOUND, 0, 0, '0, '0, 1));
      // freed slot 0 is reused, id keeps counting
      add_row(REQ_TOUCH, k2, t2, 1'b1, reply_of(ST_CREATED, 0, 2, t2, t2, 2));
      add_row(REQ_TOUCH, k2, 48'd1, 1'b1, reply_of(ST_FOUND, 0, 2, 48'd1, t2, 2));
      add_row(REQ_REMOVE, KEY_MAX, '0, 1'b1,
              reply_of(ST_FOUND, 1, 1, TIME_MAX, TIME_MAX, 1));
      add_row(REQ_REMOVE, k2, '0, 1'b1, reply_of(ST_FOUND, 0, 2, 48'd1, t2, 0));
      add_row(REQ_TOUCH, 48'h8000_0000_0000, 48'h8000_0000_0000, 1'b0, '0);
      add_row(REQ_TOUCH, 48'h0000_0000_0001, rand48(), 1'b0, '0);
      add_row(REQ_FIND, 48'h8000_0000_0000, rand48(), 1'b0, '0);
      add_row(REQ_TOUCH, 48'h8000_0000_0000, TIME_MAX, 1'b0, '0);
      n_directed = stim_rows.size();

      // bursts: fill walks distinct pool keys past capacity, drain removes them,
      // mixed traffic churns the table with some foreign keys and reserved codes
      while (stim_rows.size() < n_directed + RANDOM_ITEMS) begin
         mode = $urandom_range(0, 3);
         len  = (mode == 0) ? 40 : $urandom_range(15, 40);
         base = $urandom_range(0, KEY_POOL - 1);
         for (int k = 0; k < len; k++) begin
            roll = $urandom_range(0, 99);
            mac  = pool[(base + k) % KEY_POOL];
            case (mode)
               0: op = (roll < 90) ? REQ_TOUCH : REQ_FIND;
               1: op = (roll < 80) ? REQ_REMOVE : REQ_FIND;
               default: begin
                  op = (roll < 45) ? REQ_TOUCH :
                       (roll < 70) ? REQ_FIND :
                       (roll < 95) ? REQ_REMOVE : REQ_RESERVED;
                  if ($urandom_range(0, 9) == 0)
                     mac = rand48();
                  else
                     mac = pool[$urandom_range(0, KEY_POOL - 1)];
               end
            endcase
            add_row(op, mac, rand48(), 1'b0, '0);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (!(issue_idx == stim_rows.size() && pending_replies.size() == 0))
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### filelist.f
rtl/mdt_pkg.sv
rtl/mdt_cell.sv
rtl/mac_keyed_device_table.sv
rtl/mdt_checker.sv
bench/tb_mac_keyed_device_table.sv
